// File: hdl/rn_pkg.sv
`default_nettype none

package rn_pkg;

  // Input value width and the largest value that has a numeral
  localparam int ValueW = 12;
  localparam logic [ValueW-1:0] ValueMax = 12'd3999;

  // One converted value as it passes from the front end to the sequencer
  typedef struct packed {
    logic       range_error;
    logic [1:0] dig3;
    logic [3:0] dig2;
    logic [3:0] dig1;
    logic [3:0] dig0;
  } rn_entry_t;

  // Front-end digit extraction steps
  typedef enum logic [2:0] {
    FE_IDLE,
    FE_TH,
    FE_HU,
    FE_TE,
    FE_PUSH
  } fe_state_t;

endpackage

`default_nettype wire

// File: hdl/rn_front.sv
`default_nettype none

module rn_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [15:0]         s_tdata,   // [11:0] value, [15:12] zero
  output logic                     push_valid,
  input  wire logic                push_ready,
  output rn_pkg::rn_entry_t        push_entry
);
  import rn_pkg::*;

  fe_state_t         state;
  fe_state_t         state_next;
  logic [ValueW-1:0] rest;
  logic              err;
  logic [1:0]        th;
  logic [3:0]        hu;
  logic [3:0]        te;
  logic [ValueW-1:0] value_in;
  logic              value_bad;
  logic [13:0]       wgt;
  logic [3:0]        q;
  logic [13:0]       sub;

  assign value_in  = s_tdata[ValueW-1:0];
  assign value_bad = (value_in == '0) || (value_in > ValueMax);

  // Pick the place weight for this step and find its decimal digit
  always_comb begin
    case (state)
      FE_TH:   wgt = 14'd1000;
      FE_HU:   wgt = 14'd100;
      default: wgt = 14'd10;
    endcase
    q   = '0;
    sub = '0;
    for (int k = 1; k < 10; k++) begin
      if ({2'b00, rest} >= wgt * 14'(k)) begin
        q   = 4'(k);
        sub = wgt * 14'(k);
      end
    end
  end

  // Step through thousands, hundreds and tens, then hand the entry over
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    push_valid = 1'b0;
    case (state)
      FE_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = value_bad ? FE_PUSH : FE_TH;
        end
      end
      FE_TH:   state_next = FE_HU;
      FE_HU:   state_next = FE_TE;
      FE_TE:   state_next = FE_PUSH;
      FE_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_next = FE_IDLE;
        end
      end
      default: state_next = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the value, then peel off one digit per step
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rest <= value_in;
      err  <= value_bad;
    end
    case (state)
      FE_TH: begin
        th   <= q[1:0];
        rest <= rest - sub[ValueW-1:0];
      end
      FE_HU: begin
        hu   <= q;
        rest <= rest - sub[ValueW-1:0];
      end
      FE_TE: begin
        te   <= q;
        rest <= rest - sub[ValueW-1:0];
      end
      default: ;
    endcase
  end

  assign push_entry.range_error = err;
  assign push_entry.dig3        = th;
  assign push_entry.dig2        = hu;
  assign push_entry.dig1        = te;
  assign push_entry.dig0        = rest[3:0];

endmodule

`default_nettype wire

// File: hdl/rn_fifo.sv
`default_nettype none

module rn_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  rn_pkg::rn_entry_t in_entry,
  output logic              out_valid,
  input  wire logic         out_ready,
  output rn_pkg::rn_entry_t out_entry
);
  import rn_pkg::*;

  rn_entry_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_entry = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rn_back.sv
`default_nettype none

module rn_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  rn_pkg::rn_entry_t in_entry,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [7:0]        m_tdata,   // [7:0] symbol
  output logic              m_tlast,   // last
  output logic              m_tuser    // range_error
);
  import rn_pkg::*;

  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChV = 8'h56;
  localparam logic [7:0] ChX = 8'h58;
  localparam logic [7:0] ChL = 8'h4C;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChD = 8'h44;
  localparam logic [7:0] ChM = 8'h4D;

  localparam logic [1:0] KindOne  = 2'd0;
  localparam logic [1:0] KindFive = 2'd1;
  localparam logic [1:0] KindTen  = 2'd2;

  // Symbols in a digit's numeral
  function automatic logic [2:0] pat_len(input logic [3:0] d);
    case (d)
      4'd1, 4'd5:             pat_len = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: pat_len = 3'd2;
      4'd3, 4'd7:             pat_len = 3'd3;
      4'd8:                   pat_len = 3'd4;
      default:                pat_len = 3'd0;
    endcase
  endfunction

  // Which of the place's three letters sits at a position of the digit
  function automatic logic [1:0] pat_kind(input logic [3:0] d, input logic [1:0] p);
    case (d)
      4'd4:             pat_kind = (p == 2'd0) ? KindOne : KindFive;
      4'd5:             pat_kind = KindFive;
      4'd6, 4'd7, 4'd8: pat_kind = (p == 2'd0) ? KindFive : KindOne;
      4'd9:             pat_kind = (p == 2'd0) ? KindOne : KindTen;
      default:          pat_kind = KindOne;
    endcase
  endfunction

  function automatic logic [7:0] place_letter(input logic [1:0] pl, input logic [1:0] k);
    case ({pl, k})
      {2'd0, KindOne}:  place_letter = ChI;
      {2'd0, KindFive}: place_letter = ChV;
      {2'd0, KindTen}:  place_letter = ChX;
      {2'd1, KindOne}:  place_letter = ChX;
      {2'd1, KindFive}: place_letter = ChL;
      {2'd1, KindTen}:  place_letter = ChC;
      {2'd2, KindOne}:  place_letter = ChC;
      {2'd2, KindFive}: place_letter = ChD;
      {2'd2, KindTen}:  place_letter = ChM;
      default:          place_letter = ChM;
    endcase
  endfunction

  logic       active;
  logic       err;
  logic [1:0] place;
  logic [1:0] pos;
  logic [3:0] dig [4];
  logic [3:0] cur;
  logic [7:0] letter;
  logic       dig_end;
  logic       lower_found;
  logic [1:0] lower_place;
  logic       is_last;
  logic       emit;
  logic [1:0] load_place;

  assign in_ready = !active;
  assign emit     = active && (!m_tvalid || m_tready);
  assign cur      = dig[place];
  assign letter   = place_letter(place, pat_kind(cur, pos));
  assign dig_end  = ({1'b0, pos} + 3'd1) == pat_len(cur);
  assign is_last  = dig_end && !lower_found;

  // Find the highest nonzero place below the current one
  always_comb begin
    lower_found = 1'b0;
    lower_place = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if ((2'(i) < place) && (dig[i] != 4'd0)) begin
        lower_found = 1'b1;
        lower_place = 2'(i);
      end
    end
  end

  // Start at the highest nonzero place of a new entry
  always_comb begin
    if (in_entry.dig3 != 2'd0) begin
      load_place = 2'd3;
    end else if (in_entry.dig2 != 4'd0) begin
      load_place = 2'd2;
    end else if (in_entry.dig1 != 4'd0) begin
      load_place = 2'd1;
    end else begin
      load_place = 2'd0;
    end
  end

  // Sequencer control and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (!active && in_valid) begin
        active <= 1'b1;
      end else if (emit && (err || is_last)) begin
        active <= 1'b0;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Load digits, walk the symbols, fill the output register
  always_ff @(posedge clk) begin
    if (!active && in_valid) begin
      err    <= in_entry.range_error;
      dig[3] <= {2'b00, in_entry.dig3};
      dig[2] <= in_entry.dig2;
      dig[1] <= in_entry.dig1;
      dig[0] <= in_entry.dig0;
      place  <= load_place;
      pos    <= 2'd0;
    end else if (emit && !err) begin
      if (dig_end) begin
        place <= lower_place;
        pos   <= 2'd0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
    if (emit) begin
      m_tdata <= err ? 8'd0 : letter;
      m_tlast <= err || is_last;
      m_tuser <= err;
    end
  end

`ifndef SYNTHESIS
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
    else $error("range error result not a single zero symbol");

  a_sym_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata != 8'd0))
    else $error("numeral result carries no letter");

  a_place_live: assert property (@(posedge clk) disable iff (rst)
    active && !err |-> (dig[place] != 4'd0))
    else $error("sequencer sits on an empty place");
`endif

endmodule

`default_nettype wire

// File: hdl/integer_to_roman_numeral_top.sv
`default_nettype none

// Integer to Roman numeral converter.
// Slave stream: one 12-bit unsigned value per transfer in s_tdata[11:0].
// Master stream: one ASCII letter per transfer in m_tdata, highest place
// first, m_tlast on the final letter of each value's numeral. Values 0 and
// above 3999 give one transfer with m_tdata 0, m_tuser and m_tlast high.
// The front end takes a value and extracts thousands, hundreds and tens in
// turn, then pushes the digits into a two-entry queue; it takes no new
// value until it has pushed the last (an out-of-range value skips the
// digit steps). The sequencer loads an entry, then emits one letter per
// cycle while m_tready does not hold it, up to 15 per value. The first
// letter is registered at the output after the entry is loaded.
// Reset clears the queue, the sequencer and the output valid.
// When m_tready is low the output register holds its letter, the sequencer
// waits, and the queue and front end keep filling until they are full.
module integer_to_roman_numeral_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] symbol
  output logic             m_tlast,   // last
  output logic             m_tuser    // range_error
);
  import rn_pkg::*;

  rn_entry_t fe_entry;
  logic      fe_valid;
  logic      fe_ready;
  rn_entry_t q_entry;
  logic      q_valid;
  logic      q_ready;

  rn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_entry (fe_entry)
  );

  rn_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_entry  (fe_entry),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_entry (q_entry)
  );

  rn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_entry (q_entry),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
